// ===== sv/keyframe_playback_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// keyframe playback sequencer assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PLAYBACK_SEQUENCER_TOP_ASSERT_SVH
`define KEYFRAME_PLAYBACK_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define KFPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kfps assertion failed");

// consequent must hold in the cycle after the antecedent
`define KFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kfps assertion failed");

`else

`define KFPS_ASSERT(lbl, clk, rst_n, prop)
`define KFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/kfps_pkg.sv =====
// ----------------------------------------------------------------------------
// kfps_pkg
// widths, codes and control/status types of the keyframe playback sequencer
// ----------------------------------------------------------------------------
package kfps_pkg;

  localparam int MAX_POSES  = 16;
  localparam int POSE_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int DUR_W      = 32;
  localparam int TOTAL_W    = 36;
  localparam int TIME_W     = 48;
  localparam int LOOP_W     = 32;
  localparam int LIMIT_W    = 16;
  localparam int FPT_W      = 32;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = TIME_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESET   = 2'd1,
    ACT_ADVANCE = 2'd2
  } kfps_action_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSE_COUNT      = 2'd0,
    CFG_LOOP_LIMIT      = 2'd1,
    CFG_FIRST_POSE_TIME = 2'd2
  } kfps_cfg_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_timers;
    logic ld_read;
    logic ld_sub;
    logic ld_add;
    logic adv_add;
    logic div_start;
    logic div_sel_ptr;
    logic adv_page;
    logic adv_move;
    logic ptr_update;
    logic out_load;
  } kfps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                bad;
    logic                div_busy;
    logic                div_done;
    logic                move_hit;
  } kfps_status_t;

endpackage

// ===== sv/kfps_in_if.sv =====
// ----------------------------------------------------------------------------
// kfps_in_if
// input item channel: valid/ready handshake with the item fields
// ----------------------------------------------------------------------------
interface kfps_in_if;
  import kfps_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POSE_W-1:0]   pose_index;
  logic [DUR_W-1:0]    duration;
  logic [DUR_W-1:0]    tick;

  modport source (output valid, action, pose_index, duration, tick, input ready);
  modport sink   (input valid, action, pose_index, duration, tick, output ready);

endinterface

// ===== sv/kfps_out_if.sv =====
// ----------------------------------------------------------------------------
// kfps_out_if
// result item channel: valid/ready handshake with the result fields
// ----------------------------------------------------------------------------
interface kfps_out_if;
  import kfps_pkg::*;

  logic               valid;
  logic               ready;
  logic               changed;
  logic [POSE_W-1:0]  current_pose;
  logic [LOOP_W-1:0]  loops_done;
  logic [TOTAL_W-1:0] time_in_page;
  logic [TIME_W-1:0]  time_in_pose;
  logic               finished;
  logic               status;

  modport source (output valid, changed, current_pose, loops_done, time_in_page,
                  time_in_pose, finished, status, input ready);
  modport sink   (input valid, changed, current_pose, loops_done, time_in_page,
                  time_in_pose, finished, status, output ready);

endinterface

// ===== sv/kfps_ram.sv =====
// ----------------------------------------------------------------------------
// kfps_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module kfps_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/kfps_div.sv =====
// ----------------------------------------------------------------------------
// kfps_div
// restoring divider, one quotient bit per cycle, 48-bit by 36-bit
// ----------------------------------------------------------------------------
module kfps_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [kfps_pkg::TIME_W-1:0]    dividend_i,
  input  logic [kfps_pkg::TOTAL_W-1:0]   divisor_i,
  output logic [kfps_pkg::TIME_W-1:0]    quotient_o,
  output logic [kfps_pkg::TOTAL_W-1:0]   remainder_o,
  output logic                           busy_o,
  output logic                           done_o
);
  import kfps_pkg::*;

  logic [TIME_W-1:0]    quo_q, quo_d;
  logic [TOTAL_W-1:0]   rem_q, rem_d;
  logic [TOTAL_W-1:0]   dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [TOTAL_W:0]     rem_sh;
  logic [TOTAL_W:0]     rem_sub;
  logic                 take;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[TIME_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    take    = (rem_sh >= {1'b0, dvs_q});
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quo_d = {quo_q[TIME_W-2:0], take};
      rem_d = take ? rem_sub[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign busy_o      = busy_q;
  assign done_o      = done_q;

endmodule

// ===== sv/kfps_dp.sv =====
// ----------------------------------------------------------------------------
// kfps_dp
// datapath: duration table, timers, page total, divider and result register
// ----------------------------------------------------------------------------
module kfps_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kfps_pkg::kfps_cmd_t              cmd_i,
  output kfps_pkg::kfps_status_t           st_o,
  // item fields
  input  logic [kfps_pkg::ACTION_W-1:0]    action_i,
  input  logic [kfps_pkg::POSE_W-1:0]      pose_index_i,
  input  logic [kfps_pkg::DUR_W-1:0]       duration_i,
  input  logic [kfps_pkg::DUR_W-1:0]       tick_i,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [kfps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kfps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // result fields
  output logic                             changed_o,
  output logic [kfps_pkg::POSE_W-1:0]      current_pose_o,
  output logic [kfps_pkg::LOOP_W-1:0]      loops_done_o,
  output logic [kfps_pkg::TOTAL_W-1:0]     time_in_page_o,
  output logic [kfps_pkg::TIME_W-1:0]      time_in_pose_o,
  output logic                             finished_o,
  output logic                             status_o
);
  import kfps_pkg::*;

  // captured item
  logic [ACTION_W-1:0] action_q;
  logic [POSE_W-1:0]   idx_q;
  logic [DUR_W-1:0]    dur_q;
  logic [DUR_W-1:0]    tick_q;

  // configuration registers
  logic [COUNT_W-1:0]  pose_count_q;
  logic [LIMIT_W-1:0]  loop_limit_q;
  logic [FPT_W-1:0]    first_pose_time_q;

  // sequencer state
  logic [MAX_POSES-1:0] valid_q;
  logic                 rd_valid_q;
  logic [TOTAL_W-1:0]   page_total_q;
  logic [TIME_W-1:0]    global_q;
  logic [TOTAL_W-1:0]   page_time_q;
  logic [TIME_W-1:0]    pose_time_q;
  logic [LOOP_W-1:0]    loop_q;
  logic [POSE_W-1:0]    ptr_q;
  logic                 changed_q;

  // result register
  logic                 out_changed_q;
  logic [POSE_W-1:0]    out_pose_q;
  logic [LOOP_W-1:0]    out_loops_q;
  logic [TOTAL_W-1:0]   out_page_q;
  logic [TIME_W-1:0]    out_pose_time_q;
  logic                 out_finished_q;
  logic                 out_status_q;

  logic [DUR_W-1:0]     rd_data;
  logic [DUR_W-1:0]     cur;
  logic                 rd_en;
  logic [POSE_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   ptr_inc;
  logic                 bad;
  logic                 finished;
  logic [TIME_W:0]      gsum;
  logic [TIME_W:0]      psum;
  logic [TIME_W-1:0]    global_sat;
  logic [TIME_W-1:0]    pose_sat;
  logic [TIME_W-1:0]    div_dividend;
  logic [TOTAL_W-1:0]   div_divisor;
  logic [TIME_W-1:0]    div_quo;
  logic [TOTAL_W-1:0]   div_rem;
  logic [LOOP_W-1:0]    quo_sat;
  logic                 div_busy;
  logic                 div_done;

  // duration table
  kfps_ram #(
    .WIDTH(DUR_W),
    .DEPTH(MAX_POSES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ld_add),
    .waddr_i(idx_q),
    .wdata_i(dur_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // shared divider: page time and loop count, then pointer wrap
  kfps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  // table read select, unwritten entries read as zero
  always_comb begin
    rd_en   = cmd_i.ld_read | cmd_i.adv_add;
    rd_addr = cmd_i.ld_read ? idx_q : ptr_q;
    cur     = rd_valid_q ? rd_data : '0;
  end

  // pose count clamp and error condition
  always_comb begin
    count    = (pose_count_q > COUNT_W'(MAX_POSES)) ? COUNT_W'(MAX_POSES) : pose_count_q;
    bad      = (pose_count_q == '0) || (page_total_q == '0);
    finished = (loop_limit_q != '0) && (loop_q >= LOOP_W'(loop_limit_q));
    ptr_inc  = COUNT_W'(ptr_q) + COUNT_W'(1);
  end

  // saturating timer adds
  always_comb begin
    gsum       = {1'b0, global_q} + (TIME_W + 1)'(tick_q);
    psum       = {1'b0, pose_time_q} + (TIME_W + 1)'(tick_q);
    global_sat = gsum[TIME_W] ? '1 : gsum[TIME_W-1:0];
    pose_sat   = psum[TIME_W] ? '1 : psum[TIME_W-1:0];
    quo_sat    = (div_quo[TIME_W-1:LOOP_W] != '0) ? '1 : div_quo[LOOP_W-1:0];
  end

  // divider operands
  always_comb begin
    if (cmd_i.div_sel_ptr) begin
      div_dividend = TIME_W'(ptr_inc);
      div_divisor  = TOTAL_W'(count);
    end else begin
      div_dividend = global_q;
      div_divisor  = page_total_q;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_count_q      <= '0;
      loop_limit_q      <= '0;
      first_pose_time_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POSE_COUNT:      pose_count_q      <= cfg_data_i[COUNT_W-1:0];
        CFG_LOOP_LIMIT:      loop_limit_q      <= cfg_data_i[LIMIT_W-1:0];
        CFG_FIRST_POSE_TIME: first_pose_time_q <= cfg_data_i[FPT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      idx_q    <= pose_index_i;
      dur_q    <= duration_i;
      tick_q   <= tick_i;
    end
  end

  // table valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_add) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  // page total, timers, loop count, pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_total_q <= '0;
      global_q     <= '0;
      page_time_q  <= '0;
      pose_time_q  <= '0;
      loop_q       <= '0;
      ptr_q        <= '0;
      changed_q    <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        changed_q <= 1'b0;
      end
      if (cmd_i.clear_timers) begin
        global_q    <= '0;
        page_time_q <= '0;
        pose_time_q <= '0;
        loop_q      <= '0;
        ptr_q       <= '0;
        changed_q   <= (count != '0) && (first_pose_time_q == '0);
      end
      if (cmd_i.ld_sub) begin
        page_total_q <= page_total_q - TOTAL_W'(cur);
      end
      if (cmd_i.ld_add) begin
        page_total_q <= page_total_q + TOTAL_W'(dur_q);
      end
      if (cmd_i.adv_add) begin
        global_q    <= global_sat;
        pose_time_q <= pose_sat;
      end
      if (cmd_i.adv_page) begin
        page_time_q <= div_rem;
      end
      if (cmd_i.adv_move) begin
        loop_q      <= quo_sat;
        pose_time_q <= pose_time_q - TIME_W'(cur);
        changed_q   <= 1'b1;
      end
      if (cmd_i.ptr_update) begin
        ptr_q <= div_rem[POSE_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_changed_q   <= changed_q;
      out_pose_q      <= ptr_q;
      out_loops_q     <= loop_q;
      out_page_q      <= page_time_q;
      out_pose_time_q <= pose_time_q;
      out_finished_q  <= finished;
      out_status_q    <= bad;
    end
  end

  // status to controller
  always_comb begin
    st_o.action   = action_q;
    st_o.bad      = bad;
    st_o.div_busy = div_busy;
    st_o.div_done = div_done;
    st_o.move_hit = (pose_time_q >= TIME_W'(cur));
  end

  assign changed_o      = out_changed_q;
  assign current_pose_o = out_pose_q;
  assign loops_done_o   = out_loops_q;
  assign time_in_page_o = out_page_q;
  assign time_in_pose_o = out_pose_time_q;
  assign finished_o     = out_finished_q;
  assign status_o       = out_status_q;

endmodule

// ===== sv/kfps_ctrl.sv =====
// ----------------------------------------------------------------------------
// kfps_ctrl
// controller: sequences load, reset and advance items through the datapath
// ----------------------------------------------------------------------------
module kfps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  kfps_pkg::kfps_status_t st_i,
  output kfps_pkg::kfps_cmd_t    cmd_o
);
  import kfps_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECODE    = 9'b000000010,
    S_LD_SUB    = 9'b000000100,
    S_LD_ADD    = 9'b000001000,
    S_ADV_START = 9'b000010000,
    S_ADV_DIV   = 9'b000100000,
    S_PTR_START = 9'b001000000,
    S_PTR_DIV   = 9'b010000000,
    S_DONE      = 9'b100000000
  } kfps_state_e;

  kfps_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st_i.action)
          ACT_LOAD: begin
            cmd_o.ld_read = 1'b1;
            state_d       = S_LD_SUB;
          end
          ACT_RESET: begin
            cmd_o.clear_timers = 1'b1;
            state_d            = S_DONE;
          end
          ACT_ADVANCE: begin
            if (st_i.bad) begin
              state_d = S_DONE;
            end else begin
              cmd_o.adv_add = 1'b1;
              state_d       = S_ADV_START;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_LD_SUB: begin
        cmd_o.ld_sub = 1'b1;
        state_d      = S_LD_ADD;
      end
      S_LD_ADD: begin
        cmd_o.ld_add = 1'b1;
        state_d      = S_DONE;
      end
      S_ADV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_ADV_DIV;
      end
      S_ADV_DIV: begin
        if (st_i.div_done) begin
          cmd_o.adv_page = 1'b1;
          if (st_i.move_hit) begin
            cmd_o.adv_move = 1'b1;
            state_d        = S_PTR_START;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PTR_START: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_ptr = 1'b1;
        state_d           = S_PTR_DIV;
      end
      S_PTR_DIV: begin
        if (st_i.div_done) begin
          cmd_o.ptr_update = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/keyframe_playback_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_playback_sequencer_top
// looping keyframe duration table with pose, page and loop timers
// ----------------------------------------------------------------------------
// One item at a time. A load item passes the decode, subtract and add states, a
// reset item only decode, and an advance item with a pose count or page total of
// zero goes from decode straight to done. An advance that stays on its pose runs
// one division, and one that moves to the next pose runs a second one. Advances
// use the shared restoring divider, which produces one quotient bit per cycle over
// 48 steps, once for global time by page total and once more for the pointer wrap.
// The next item is accepted while the previous result still waits in the output register.
`include "keyframe_playback_sequencer_top_assert.svh"

module keyframe_playback_sequencer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  kfps_in_if.sink                         in_if,
  kfps_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [kfps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kfps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kfps_pkg::*;

  kfps_cmd_t    cmd;
  kfps_status_t st;

  // controller
  kfps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath
  kfps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .action_i      (in_if.action),
    .pose_index_i  (in_if.pose_index),
    .duration_i    (in_if.duration),
    .tick_i        (in_if.tick),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .changed_o     (out_if.changed),
    .current_pose_o(out_if.current_pose),
    .loops_done_o  (out_if.loops_done),
    .time_in_page_o(out_if.time_in_page),
    .time_in_pose_o(out_if.time_in_pose),
    .finished_o    (out_if.finished),
    .status_o      (out_if.status)
  );

  // an accepted item blocks the input until its result is queued
  `KFPS_ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, in_if.valid && in_if.ready, !in_if.ready)
  // divider is never restarted mid-division
  `KFPS_ASSERT(a_div_no_restart, clk_i, rst_ni, !(cmd.div_start && st.div_busy))
  // result register is loaded only when free or being drained
  `KFPS_ASSERT(a_out_load_free, clk_i, rst_ni, !cmd.out_load || !out_if.valid || out_if.ready)
  // a load of the result raises valid in the next cycle
  `KFPS_ASSERT_NEXT(a_out_load_valid, clk_i, rst_ni, cmd.out_load, out_if.valid)

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyframe playback sequencer. Items go in on the
// input channel, and an in-bench sequencer model predicts each result from
// its own copy of the duration table, timers and registers. Every result is
// compared field by field. Directed items come first, then random traffic
// under several register settings and idle patterns, then a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import kfps_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned END_WAIT       = 150;
  localparam int unsigned PHASE_ITEMS    = 250;

  typedef struct packed {
    logic               changed;
    logic [POSE_W-1:0]  pose;
    logic [LOOP_W-1:0]  loops;
    logic [TOTAL_W-1:0] page_t;
    logic [TIME_W-1:0]  pose_t;
    logic               finished;
    logic               status;
  } kf_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kfps_in_if  in_ch ();
  kfps_out_if out_ch ();

  keyframe_playback_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // sequencer model state and register mirror
  logic [DUR_W-1:0]   dur_tab [MAX_POSES];
  logic [TOTAL_W-1:0] page_sum;
  logic [TIME_W-1:0]  gtime;
  logic [TOTAL_W-1:0] page_pos;
  logic [TIME_W-1:0]  pose_acc;
  logic [LOOP_W-1:0]  loop_cnt;
  logic [POSE_W-1:0]  pose_ptr;
  logic [COUNT_W-1:0] cfg_poses;
  logic [LIMIT_W-1:0] cfg_limit;
  logic [FPT_W-1:0]   cfg_first;

  kf_result_t  pending_results [$];
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [TIME_W-1:0] sat_time_add(logic [TIME_W-1:0] a,
                                                     logic [DUR_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // append one expected result at the tail of the queue
  function automatic void queue_expected(kf_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // advance the sequencer model by one item and return its result
  function automatic kf_result_t step_sequencer(logic [ACTION_W-1:0] act,
                                                logic [POSE_W-1:0] idx,
                                                logic [DUR_W-1:0] dur,
                                                logic [DUR_W-1:0] tk);
    int unsigned n;
    logic [TIME_W-1:0] quo;
    logic [DUR_W-1:0]  cur;
    kf_result_t        r;
    n = (cfg_poses > MAX_POSES) ? MAX_POSES : cfg_poses;
    r.changed = 1'b0;
    case (act)
      ACT_LOAD: begin
        page_sum     = page_sum - {4'd0, dur_tab[idx]} + {4'd0, dur};
        dur_tab[idx] = dur;
      end
      ACT_RESET: begin
        gtime     = '0;
        page_pos  = '0;
        pose_acc  = '0;
        loop_cnt  = '0;
        pose_ptr  = '0;
        r.changed = (n > 0) && (cfg_first == '0);
      end
      ACT_ADVANCE: begin
        if (n != 0 && page_sum != '0) begin
          gtime    = sat_time_add(gtime, tk);
          page_pos = TOTAL_W'(gtime % page_sum);
          pose_acc = sat_time_add(pose_acc, tk);
          cur      = dur_tab[pose_ptr];
          if (pose_acc >= {16'd0, cur}) begin
            quo       = gtime / page_sum;
            loop_cnt  = (quo > 48'hFFFF_FFFF) ? {LOOP_W{1'b1}} : quo[LOOP_W-1:0];
            pose_acc  = pose_acc - {16'd0, cur};
            pose_ptr  = POSE_W'((pose_ptr + 1) % n);
            r.changed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.pose     = pose_ptr;
    r.loops    = loop_cnt;
    r.page_t   = page_pos;
    r.pose_t   = pose_acc;
    r.finished = (cfg_limit != '0) && (loop_cnt >= {16'd0, cfg_limit});
    r.status   = (n == 0) || (page_sum == '0);
    return r;
  endfunction

  // send one item, starting and ending at a falling edge
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [POSE_W-1:0] idx,
                           input logic [DUR_W-1:0] dur, input logic [DUR_W-1:0] tk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.pose_index <= idx;
    in_ch.duration   <= dur;
    in_ch.tick       <= tk;
    do @(posedge clk_i); while (!in_ch.ready);
    queue_expected(step_sequencer(act, idx, dur, tk));
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input kfps_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_POSE_COUNT:      cfg_poses = data[COUNT_W-1:0];
      CFG_LOOP_LIMIT:      cfg_limit = data[LIMIT_W-1:0];
      CFG_FIRST_POSE_TIME: cfg_first = data[FPT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // program all registers once the block is idle
  task automatic apply_config(input logic [COUNT_W-1:0] poses,
                              input logic [LIMIT_W-1:0] limit,
                              input logic [FPT_W-1:0] first);
    drain_results();
    write_reg(CFG_POSE_COUNT, {27'd0, poses});
    write_reg(CFG_LOOP_LIMIT, {16'd0, limit});
    write_reg(CFG_FIRST_POSE_TIME, first);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] rand_tick();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return $urandom_range(30);
    if (pick < 85) return $urandom_range(200);
    return $urandom;
  endfunction

  // error paths, saturation, zero durations, wrap and pointer past the count
  task automatic test_directed_cases();
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'd5);
    send_item(ACT_RESET, 4'd0, 32'd0, 32'd0);
    send_item(ACT_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 4'd0, 32'd1, 32'd0);
    send_item(ACT_LOAD, 4'hF, 32'd0, 32'hFFFF_FFFF);
    // single one-unit pose: loop count saturates after two full ticks
    apply_config(5'd1, 16'hFFFF, 32'd0);
    send_item(ACT_RESET, 4'd0, 32'd0, 32'd0);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'd0);
    // oversized pose count, nonzero start time
    apply_config(5'd31, 16'd1, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 4'd3, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_LOAD, 4'hF, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_RESET, 4'd0, 32'd0, 32'd0);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'd1);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'd0);
    send_item(ACT_LOAD, 4'd0, 32'd0, 32'd0);
    // pointer now beyond the count, then an empty page
    apply_config(5'd2, 16'd0, 32'd0);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'd0);
    send_item(ACT_LOAD, 4'd3, 32'd0, 32'd0);
    send_item(ACT_LOAD, 4'hF, 32'd0, 32'd0);
    send_item(ACT_ADVANCE, 4'd0, 32'd0, 32'd7);
    send_item(ACT_RESET, 4'd0, 32'd0, 32'd0);
  endtask

  // mostly advances, some loads of mostly small durations, a few resets and noise
  task automatic run_random_items(input int unsigned count);
    int unsigned pick;
    logic [DUR_W-1:0] dur;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        pick = $urandom_range(99);
        dur  = (pick < 70) ? $urandom_range(40) : (pick < 80) ? 32'd0 : $urandom;
        send_item(ACT_LOAD, POSE_W'($urandom_range(15)), dur, $urandom);
      end else if (pick < 14) begin
        send_item(ACT_RESET, POSE_W'($urandom_range(15)), $urandom, $urandom);
      end else if (pick < 16) begin
        send_item(ACT_UNUSED, POSE_W'($urandom_range(15)), $urandom, $urandom);
      end else begin
        send_item(ACT_ADVANCE, POSE_W'($urandom_range(15)), $urandom, rand_tick());
      end
    end
  endtask

  // random traffic in four idle patterns, two register settings each
  task automatic test_random_traffic();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    apply_config(5'd16, 16'd0, 32'd0);
    run_random_items(PHASE_ITEMS);
    apply_config(5'd1, 16'hFFFF, 32'hFFFF_FFFF);
    run_random_items(PHASE_ITEMS);

    tx_idle_pct = 76;
    apply_config(COUNT_W'($urandom_range(1, 16)), LIMIT_W'($urandom_range(1, 8)), 32'd0);
    run_random_items(PHASE_ITEMS);
    apply_config(5'd31, 16'd3, $urandom);
    run_random_items(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_stall_pct = 76;
    apply_config(COUNT_W'($urandom_range(2, 5)), LIMIT_W'($urandom_range(4)), 32'd0);
    run_random_items(PHASE_ITEMS);
    apply_config(COUNT_W'($urandom_range(31)), LIMIT_W'($urandom_range(65535)), $urandom);
    run_random_items(PHASE_ITEMS);

    tx_idle_pct = 8;
    rx_stall_pct = 8;
    apply_config(5'd8, 16'd2, 32'd0);
    run_random_items(PHASE_ITEMS);
    apply_config(COUNT_W'($urandom_range(1, 16)), 16'd1, 32'd0);
    run_random_items(PHASE_ITEMS);
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    apply_config(5'd4, 16'd5, 32'd0);
    rx_hold = LONG_HOLD;
    repeat (24) send_item(ACT_ADVANCE, 4'd0, 32'd0, rand_tick());
    drain_results();
  endtask

  // output side: random stalls, plus the long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin : result_check
    kf_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result item: expected none actual pose %0h",
                 $time, out_ch.current_pose);
      end else begin
        want = pending_results.pop_front();
        check_field("changed", want.changed, out_ch.changed);
        check_field("current_pose", want.pose, out_ch.current_pose);
        check_field("loops_done", want.loops, out_ch.loops_done);
        check_field("time_in_page", want.page_t, out_ch.time_in_page);
        check_field("time_in_pose", want.pose_t, out_ch.time_in_pose);
        check_field("finished", want.finished, out_ch.finished);
        check_field("status", want.status, out_ch.status);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = '0;
    in_ch.pose_index = '0;
    in_ch.duration   = '0;
    in_ch.tick       = '0;
    out_ch.ready     = 1'b0;
    err_cnt          = 0;
    quiet_cycles     = 0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    rx_hold          = 0;
    foreach (dur_tab[i]) dur_tab[i] = '0;
    page_sum  = '0;
    gtime     = '0;
    page_pos  = '0;
    pose_acc  = '0;
    loop_cnt  = '0;
    pose_ptr  = '0;
    cfg_poses = '0;
    cfg_limit = '0;
    cfg_first = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_traffic();
    test_backpressure();

    repeat (END_WAIT) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
